// ===== rtl/core/i2c_slave_motor_command_port_assert.svh =====
// assertion macros for the i2c slave motor command port
// used by the top level; no other dependencies
`ifndef I2C_SLAVE_MOTOR_COMMAND_PORT_ASSERT_SVH
`define I2C_SLAVE_MOTOR_COMMAND_PORT_ASSERT_SVH

`ifndef SYNTHESIS

// concurrent property check, disabled while reset is asserted
`define I2CMCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2cmcp assertion failed");

// expression that must never be true at a clock edge
`define I2CMCP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `I2CMCP_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define I2CMCP_ASSERT(lbl, clk, rst_n, prop)
`define I2CMCP_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/i2cmcp_pkg.sv =====
// shared types and constants of the i2c slave motor command port
// no dependencies
package i2cmcp_pkg;

  localparam int unsigned RX_BYTES_DEF = 3;
  localparam int unsigned TX_BYTES_DEF = 4;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PTR_W    = 8;
  // only the first four readback bytes are ever written by a command
  localparam int unsigned RB_BYTES = 4;
  localparam int unsigned RB_IDX_W = 2;

  localparam logic [BYTE_W-1:0] READ_PAST_END = 8'hFF;

  // event codes; unlisted codes behave as the ending event
  typedef enum logic [OP_W-1:0] {
    OP_WR_ADDR = 3'd0,
    OP_WR_DATA = 3'd1,
    OP_RD_ADDR = 3'd2,
    OP_RD_DATA = 3'd3,
    OP_END     = 3'd4
  } op_e;

  // command byte codes
  localparam logic [BYTE_W-1:0] CMD_ONE_FWD = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_ONE_BWD = 8'hFE;
  localparam logic [BYTE_W-1:0] CMD_ONE_OFF = 8'hFD;
  localparam logic [BYTE_W-1:0] CMD_TWO_FWD = 8'hFC;
  localparam logic [BYTE_W-1:0] CMD_TWO_BWD = 8'hFB;
  localparam logic [BYTE_W-1:0] CMD_TWO_OFF = 8'hFA;

  localparam logic MOTOR_ONE = 1'b0;
  localparam logic MOTOR_TWO = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BWD  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic              drive_valid;
    logic              drive_motor;
    mode_e             drive_mode;
    logic [BYTE_W-1:0] drive_speed;
  } res_t;

endpackage

// ===== rtl/core/i2cmcp_if.sv =====
// valid/ready channel interfaces for events in and results out
// depends on i2cmcp_pkg
interface i2cmcp_in_if import i2cmcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, output op, output write_data, input ready);
  modport sink   (input valid, input op, input write_data, output ready);
endinterface

interface i2cmcp_out_if import i2cmcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              read_valid;
  logic              drive_valid;
  logic              drive_motor;
  logic [1:0]        drive_mode;
  logic [BYTE_W-1:0] drive_speed;

  modport source (output valid, output read_data, output read_valid, output drive_valid,
                  output drive_motor, output drive_mode, output drive_speed, input ready);
  modport sink   (input valid, input read_data, input read_valid, input drive_valid,
                  input drive_motor, input drive_mode, input drive_speed, output ready);
endinterface

// ===== rtl/core/i2cmcp_engine.sv =====
// event engine: receive store, read pointer, readback table, command decode
// depends on i2cmcp_pkg
module i2cmcp_engine import i2cmcp_pkg::*; #(
  parameter int unsigned RX_BYTES = RX_BYTES_DEF,
  parameter int unsigned TX_BYTES = TX_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  item_t item_i,
  output res_t  res_o
);

  localparam int unsigned IdxW = $clog2(RX_BYTES);

  logic [BYTE_W-1:0] rx_q [RX_BYTES];
  logic [BYTE_W-1:0] rx_d [RX_BYTES];
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [BYTE_W-1:0] rb_q [RB_BYTES];
  logic [BYTE_W-1:0] rb_d [RB_BYTES];

  logic              cmd_ok;
  logic              cmd_motor;
  mode_e             cmd_mode;
  logic [BYTE_W-1:0] rd_byte;

  // command byte decode
  always_comb begin
    cmd_ok    = 1'b1;
    cmd_motor = MOTOR_ONE;
    cmd_mode  = MODE_STOP;
    unique case (rx_q[0])
      CMD_ONE_FWD: begin cmd_motor = MOTOR_ONE; cmd_mode = MODE_FWD;  end
      CMD_ONE_BWD: begin cmd_motor = MOTOR_ONE; cmd_mode = MODE_BWD;  end
      CMD_ONE_OFF: begin cmd_motor = MOTOR_ONE; cmd_mode = MODE_STOP; end
      CMD_TWO_FWD: begin cmd_motor = MOTOR_TWO; cmd_mode = MODE_FWD;  end
      CMD_TWO_BWD: begin cmd_motor = MOTOR_TWO; cmd_mode = MODE_BWD;  end
      CMD_TWO_OFF: begin cmd_motor = MOTOR_TWO; cmd_mode = MODE_STOP; end
      default:     cmd_ok = 1'b0;
    endcase
  end

  // readback byte; entries above the written ones stay zero
  always_comb begin
    if (ptr_q >= PTR_W'(TX_BYTES)) begin
      rd_byte = READ_PAST_END;
    end else if (ptr_q[PTR_W-1:RB_IDX_W] == '0) begin
      rd_byte = rb_q[ptr_q[RB_IDX_W-1:0]];
    end else begin
      rd_byte = '0;
    end
  end

  always_comb begin
    rx_d  = rx_q;
    idx_d = idx_q;
    ptr_d = ptr_q;
    rb_d  = rb_q;
    res_o = '0;
    unique case (item_i.op)
      OP_WR_ADDR: begin
        idx_d = '0;
      end
      OP_WR_DATA: begin
        for (int unsigned i = 0; i < RX_BYTES; i++) begin
          if (idx_q == IdxW'(i)) begin
            rx_d[i] = item_i.write_data;
          end
        end
        idx_d = (idx_q == IdxW'(RX_BYTES - 1)) ? '0 : idx_q + 1'b1;
      end
      OP_RD_ADDR, OP_RD_DATA: begin
        res_o.read_data  = rd_byte;
        res_o.read_valid = 1'b1;
        ptr_d            = ptr_q + 1'b1;
      end
      default: begin
        if (idx_q == IdxW'(2)) begin
          if (cmd_ok) begin
            res_o.drive_valid = 1'b1;
            res_o.drive_motor = cmd_motor;
            res_o.drive_mode  = cmd_mode;
            res_o.drive_speed = (cmd_mode != MODE_STOP) ? rx_q[1] : '0;
            rb_d[{cmd_motor, 1'b0}] = (cmd_mode == MODE_FWD) ? rx_q[1] : '0;
            rb_d[{cmd_motor, 1'b1}] = (cmd_mode == MODE_BWD) ? rx_q[1] : '0;
          end
        end else begin
          ptr_d = rx_q[0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q  <= '{default: '0};
      idx_q <= '0;
      ptr_q <= '0;
      rb_q  <= '{default: '0};
    end else if (accept_i) begin
      rx_q  <= rx_d;
      idx_q <= idx_d;
      ptr_q <= ptr_d;
      rb_q  <= rb_d;
    end
  end

endmodule

// ===== rtl/core/i2c_slave_motor_command_port.sv =====
// top level of the i2c slave motor command port: channels and result buffering
// depends on i2cmcp_pkg, i2cmcp_if, i2cmcp_engine and the assertion macro header
`include "i2c_slave_motor_command_port_assert.svh"

// usage
//   in_i carries one decoded i2c slave event per transaction (op, write_data).
//   out_o returns exactly one result per event: readback byte on read events,
//   drive fields when an ending event runs a motor command, all zero otherwise.
// latency and throughput
//   the engine works out the result and new state combinationally; the result
//   is registered in the output register, or in the skid register on a stall.
//   one event per cycle is taken for as long as results are consumed.
// stalls
//   a result register plus one skid register sit in front of out_o, so one
//   more event is taken while a result waits; ready drops only when both hold
//   results, and rises again the cycle after the receiver takes one.
// reset
//   clears the receive store and index, the read pointer, the readback table
//   and both result valid flags; no clearing pass, events are taken at once.
module i2c_slave_motor_command_port import i2cmcp_pkg::*; #(
  parameter int unsigned RX_BYTES = RX_BYTES_DEF,
  parameter int unsigned TX_BYTES = TX_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  i2cmcp_in_if.sink            in_i,
  i2cmcp_out_if.source         out_o
);

  item_t item;
  res_t  res;
  logic  in_fire;
  logic  out_fire;

  // output register and skid register
  res_t  out_q;
  logic  out_valid_q;
  res_t  skid_q;
  logic  skid_valid_q;

  // only a full skid register blocks new events
  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign item.op         = in_i.op;
  assign item.write_data = in_i.write_data;

  i2cmcp_engine #(
    .RX_BYTES (RX_BYTES),
    .TX_BYTES (TX_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .item_i   (item),
    .res_o    (res)
  );

  // result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q && out_fire) begin
        // skid moves up; no event taken this cycle
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else if (!out_valid_q || out_fire) begin
        out_valid_q  <= in_fire;
      end else begin
        // output stalled, park a new result if one arrives
        skid_valid_q <= skid_valid_q || in_fire;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q && out_fire) begin
      out_q <= skid_q;
    end else if (!out_valid_q || out_fire) begin
      if (in_fire) begin
        out_q <= res;
      end
    end else begin
      if (in_fire) begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_q.read_data;
  assign out_o.read_valid  = out_q.read_valid;
  assign out_o.drive_valid = out_q.drive_valid;
  assign out_o.drive_motor = out_q.drive_motor;
  assign out_o.drive_mode  = out_q.drive_mode;
  assign out_o.drive_speed = out_q.drive_speed;

  // a parked result always has one ahead of it
  `I2CMCP_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  // an event taken while the output stalls lands in the skid register
  `I2CMCP_ASSERT(a_stall_to_skid, clk_i, rst_ni,
                 (in_fire && out_valid_q && !out_o.ready) |=> skid_valid_q)
  // a single event never yields both a read byte and a drive command
  `I2CMCP_ASSERT_NEVER(a_read_xor_drive, clk_i, rst_ni,
                       out_valid_q && out_q.read_valid && out_q.drive_valid)

endmodule

// ===== sim/motor_port_checker.sv =====
// result checker for the i2c slave motor command port: watches both channels,
// predicts every result from its own copy of the port state and compares in order
// depends on i2cmcp_pkg and the channel interfaces in i2cmcp_if
`timescale 1ns / 100ps

module motor_port_checker import i2cmcp_pkg::*; #(
  parameter int unsigned RX_BYTES = RX_BYTES_DEF,
  parameter int unsigned TX_BYTES = TX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cmcp_in_if        ev_mon,
  i2cmcp_out_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned drive_count_o,
  output int unsigned read_count_o
);

  // predicted port state
  logic [BYTE_W-1:0] rx_store [RX_BYTES];
  int unsigned       rx_idx;
  logic [PTR_W-1:0]  rd_ptr;
  logic [BYTE_W-1:0] readback [TX_BYTES];

  res_t pending_results[$];

  function automatic res_t predict_event_result(logic [OP_W-1:0] op, logic [BYTE_W-1:0] wd);
    res_t              r;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] spd;
    int unsigned       base;
    r = '0;
    if (rx_idx >= RX_BYTES) rx_idx = 0;
    case (op)
      OP_WR_ADDR: rx_idx = 0;
      OP_WR_DATA: begin
        rx_store[rx_idx] = wd;
        rx_idx = (rx_idx + 1 >= RX_BYTES) ? 0 : rx_idx + 1;
      end
      OP_RD_ADDR, OP_RD_DATA: begin
        r.read_data  = (rd_ptr >= TX_BYTES) ? READ_PAST_END : readback[rd_ptr];
        r.read_valid = 1'b1;
        rd_ptr       = rd_ptr + 1'b1;
      end
      default: begin
        // ending event, unused codes included
        if (rx_idx == 2) begin
          cmd = rx_store[0];
          spd = rx_store[1];
          r.drive_valid = 1'b1;
          case (cmd)
            CMD_ONE_FWD: begin r.drive_motor = MOTOR_ONE; r.drive_mode = MODE_FWD;  end
            CMD_ONE_BWD: begin r.drive_motor = MOTOR_ONE; r.drive_mode = MODE_BWD;  end
            CMD_ONE_OFF: begin r.drive_motor = MOTOR_ONE; r.drive_mode = MODE_STOP; end
            CMD_TWO_FWD: begin r.drive_motor = MOTOR_TWO; r.drive_mode = MODE_FWD;  end
            CMD_TWO_BWD: begin r.drive_motor = MOTOR_TWO; r.drive_mode = MODE_BWD;  end
            CMD_TWO_OFF: begin r.drive_motor = MOTOR_TWO; r.drive_mode = MODE_STOP; end
            default:     r.drive_valid = 1'b0;
          endcase
          if (r.drive_valid) begin
            r.drive_speed      = (r.drive_mode != MODE_STOP) ? spd : '0;
            base               = (r.drive_motor == MOTOR_TWO) ? 2 : 0;
            readback[base]     = (r.drive_mode == MODE_FWD) ? spd : '0;
            readback[base + 1] = (r.drive_mode == MODE_BWD) ? spd : '0;
          end
        end else begin
          rd_ptr = rx_store[0];
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      foreach (rx_store[i]) rx_store[i] = '0;
      foreach (readback[i]) readback[i] = '0;
      rx_idx = 0;
      rd_ptr = '0;
      pending_results.delete();
      fail_count_o  = 0;
      drive_count_o = 0;
      read_count_o  = 0;
      pending_o     = 0;
    end else begin
      // results first: none can belong to an event taken at this same edge
      if (res_mon.valid && res_mon.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rd %h/%b drv %b/%b/%h/%h",
                   $time, res_mon.read_data, res_mon.read_valid, res_mon.drive_valid,
                   res_mon.drive_motor, res_mon.drive_mode, res_mon.drive_speed);
          fail_count_o++;
        end else begin
          exp_r = pending_results.pop_front();
          compare_field("read_data", exp_r.read_data, res_mon.read_data);
          compare_field("read_valid", BYTE_W'(exp_r.read_valid),
                        BYTE_W'(res_mon.read_valid));
          compare_field("drive_valid", BYTE_W'(exp_r.drive_valid),
                        BYTE_W'(res_mon.drive_valid));
          compare_field("drive_motor", BYTE_W'(exp_r.drive_motor),
                        BYTE_W'(res_mon.drive_motor));
          compare_field("drive_mode", BYTE_W'(exp_r.drive_mode),
                        BYTE_W'(res_mon.drive_mode));
          compare_field("drive_speed", exp_r.drive_speed, res_mon.drive_speed);
          if (exp_r.drive_valid) drive_count_o++;
          if (exp_r.read_valid) read_count_o++;
        end
      end
      if (ev_mon.valid && ev_mon.ready)
        pending_results.push_back(predict_event_result(ev_mon.op, ev_mon.write_data));
      pending_o = pending_results.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// top of the i2c slave motor command port testbench: clock, reset, event
// stimulus, result back-pressure and the verdict
// depends on i2cmcp_pkg, i2cmcp_if, the port rtl and motor_port_checker
`timescale 1ns / 100ps

module tb_top;
  import i2cmcp_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 350;

  logic clk_i;
  logic rst_ni;

  // idling percentages of the current phase, read by both drivers
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned events_sent;

  int unsigned fail_count;
  int unsigned pending_cnt;
  int unsigned drive_cnt;
  int unsigned read_cnt;

  i2cmcp_in_if  ev_ch ();
  i2cmcp_out_if res_ch ();

  i2c_slave_motor_command_port uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_ch),
    .out_o  (res_ch)
  );

  motor_port_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_mon        (ev_ch),
    .res_mon       (res_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cnt),
    .drive_count_o (drive_cnt),
    .read_count_o  (read_cnt)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // generous hard stop, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", pending_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: ready changes only at the falling edge, at the phase's stall rate
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one event transaction: optional idle gap, then hold valid until accepted
  task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wd);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      // lower valid here and raise it again only at a later falling edge
      ev_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ev_ch.valid      <= 1'b1;
    ev_ch.op         <= op;
    ev_ch.write_data <= wd;
    @(posedge clk_i);
    while (!(ev_ch.valid && ev_ch.ready)) @(posedge clk_i);
    @(negedge clk_i);
    events_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_command();
    case ($urandom_range(5))
      0:       return CMD_ONE_FWD;
      1:       return CMD_ONE_BWD;
      2:       return CMD_ONE_OFF;
      3:       return CMD_TWO_FWD;
      4:       return CMD_TWO_BWD;
      default: return CMD_TWO_OFF;
    endcase
  endfunction

  // random traffic: mostly well-formed master transfers with random content,
  // the rest raw events with any op code including the unused ones
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned kind;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] ptr;
    target = events_sent + count;
    while (events_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // motor command write: address, command byte, speed byte, stop
        cmd = ($urandom_range(9) < 8) ? pick_command() : BYTE_W'($urandom_range(255));
        send_event(OP_WR_ADDR, BYTE_W'($urandom_range(255)));
        send_event(OP_WR_DATA, cmd);
        send_event(OP_WR_DATA, BYTE_W'($urandom_range(255)));
        send_event(OP_END, BYTE_W'($urandom_range(255)));
        // a second stop while the index still sits at two runs it again
        if ($urandom_range(3) == 0) send_event(OP_END, BYTE_W'($urandom_range(255)));
      end else if (kind < 80) begin
        // pointer set by a one-byte write, then a read burst
        ptr = ($urandom_range(3) != 0) ? BYTE_W'($urandom_range(5))
                                       : BYTE_W'($urandom_range(255));
        send_event(OP_WR_ADDR, BYTE_W'($urandom_range(255)));
        send_event(OP_WR_DATA, ptr);
        send_event(OP_END, BYTE_W'($urandom_range(255)));
        send_event(OP_RD_ADDR, BYTE_W'($urandom_range(255)));
        repeat ($urandom_range(1, 5)) send_event(OP_RD_DATA, BYTE_W'($urandom_range(255)));
        send_event(OP_END, BYTE_W'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(OP_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst_ni           = 1'b0;
    ev_ch.valid      = 1'b0;
    ev_ch.op         = OP_WR_ADDR;
    ev_ch.write_data = '0;
    res_ch.ready     = 1'b0;
    sender_idle_pct  = 0;
    recv_stall_pct   = 0;
    events_sent      = 0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling
    // stop right after reset: pointer takes receive byte 0, still zero
    send_event(OP_END, 8'h00);
    send_event(OP_RD_ADDR, 8'h00);
    // motor one forward at full speed, then a repeated stop via an unused op code
    send_event(OP_WR_ADDR, 8'hFF);
    send_event(OP_WR_DATA, CMD_ONE_FWD);
    send_event(OP_WR_DATA, 8'hFF);
    send_event(OP_END, 8'h00);
    send_event(3'd7, 8'hFF);
    // motor two backward at the lowest nonzero speed
    send_event(OP_WR_ADDR, 8'h00);
    send_event(OP_WR_DATA, CMD_TWO_BWD);
    send_event(OP_WR_DATA, 8'h01);
    send_event(OP_END, 8'h00);
    // unknown command byte: nothing driven, table kept
    send_event(OP_WR_ADDR, 8'h00);
    send_event(OP_WR_DATA, 8'h00);
    send_event(OP_WR_DATA, 8'hAA);
    send_event(OP_END, 8'h00);
    // pointer to 0xFE, then reads past the table end and across the wrap to zero
    send_event(OP_WR_ADDR, 8'h00);
    send_event(OP_WR_DATA, 8'hFE);
    send_event(3'd5, 8'h00);
    send_event(OP_RD_ADDR, 8'h00);
    send_event(OP_RD_DATA, 8'hFF);
    send_event(OP_RD_DATA, 8'h00);
    send_event(OP_RD_DATA, 8'h00);
    send_event(OP_RD_DATA, 8'h00);
    send_event(OP_RD_DATA, 8'h00);
    send_event(3'd6, 8'h55);

    // random part over four idling phases
    run_random(RANDOM_PER_PHASE);
    sender_idle_pct = 68;
    recv_stall_pct  = 0;
    run_random(RANDOM_PER_PHASE);
    sender_idle_pct = 0;
    recv_stall_pct  = 68;
    run_random(RANDOM_PER_PHASE);
    sender_idle_pct = 22;
    recv_stall_pct  = 22;
    run_random(RANDOM_PER_PHASE);

    ev_ch.valid <= 1'b0;

    // drain: the hard stop above covers a port that never answers
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("covered %0d events under four idle/stall mixes", events_sent);
    $display("results checked include %0d motor commands and %0d readback bytes",
             drive_cnt, read_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/i2cmcp_pkg.sv
rtl/core/i2cmcp_if.sv
rtl/core/i2cmcp_engine.sv
rtl/core/i2c_slave_motor_command_port.sv
sim/motor_port_checker.sv
sim/tb_top.sv
